@@ sv/trq_pkg.sv @@
// ============================================================================
// trq_pkg: shared types and constants of the task ready queue
// Field widths, operation and status codes, and the command and status
// groups that join the controller to the datapath.
// ============================================================================
`default_nettype none

package trq_pkg;

    localparam int FUNC_W         = 2;
    localparam int ID_W           = 8;
    localparam int PRIO_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int LIST_DEPTH_DEF = 16;

    // Operation codes of an input word
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_HEAD   = 2'd1,
        FUNC_NAMED  = 2'd2,
        FUNC_PRIO   = 2'd3
    } t_func;

    // Status codes of a result word
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the input word, restart the walker at slot 0
        logic shift_start;  // restart the walker just past the chosen slot
        logic step;         // advance the walker by one slot
        logic shift_mode;   // walker moves slots down instead of searching
        logic finish;       // update the count and load the result word
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_append;    // captured word is an append
        logic walk_done;    // walker has passed the last held slot
        logic found;        // search picked a slot
        logic out_free;     // result register can take a new word
    } t_sts;

endpackage

`default_nettype wire

@@ sv/trq_if.sv @@
// ============================================================================
// trq_if: request and response channels of the task ready queue
// Valid/ready channels; a word moves at a clock edge with both high.
// ============================================================================
`default_nettype none

interface trq_req_if;
    import trq_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority;

    modport source (output valid, output func, output task_id, output task_priority,
                    input ready);
    modport sink   (input valid, input func, input task_id, input task_priority,
                    output ready);
endinterface

interface trq_rsp_if;
    import trq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     removed_id;
    logic [PRIO_W-1:0]   removed_priority;

    modport source (output valid, output status, output removed_id,
                    output removed_priority, input ready);
    modport sink   (input valid, input status, input removed_id,
                    input removed_priority, output ready);
endinterface

`default_nettype wire

@@ sv/task_ready_queue.sv @@
// ============================================================================
// task_ready_queue: ordered ready list of a task scheduler
// Append, remove head, remove named task, remove highest-priority task.
// ============================================================================
// The queue takes one request word at a time and answers each with one
// response word. An append skips the walks and goes on to load its result
// register. A removal first searches the held tasks, then moves the tasks
// behind the removed one down one place, and then loads the result
// register; a removal that finds no task skips the move. A single walker
// does both walks and reads one slot of the one-read, one-write slot
// memory per cycle. The next request is taken on the cycle after the
// result is loaded. The response sits in an output register, so a new
// request is taken while a finished response waits. That request's own
// result is held back until the register is free. The slot memory needs
// no clearing after reset; only slots below the entry count are ever read.
`default_nettype none

module task_ready_queue #(
    parameter int LIST_DEPTH = trq_pkg::LIST_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    trq_req_if.sink    i_req,
    trq_rsp_if.source  o_rsp
);
    import trq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Sequencer
    trq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_func     (t_func'(i_req.func)),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Slot store, walker and result register
    trq_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_func             (i_req.func),
        .i_task_id          (i_req.task_id),
        .i_task_priority    (i_req.task_priority),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status           (o_rsp.status),
        .o_removed_id       (o_rsp.removed_id),
        .o_removed_priority (o_rsp.removed_priority)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire

@@ sv/trq_ctrl.sv @@
// ============================================================================
// trq_ctrl: sequencer of the task ready queue
// Takes one word at a time, runs the search walk and the shift walk, and
// hands the result to the output register once it is free.
// ============================================================================
`default_nettype none

module trq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  trq_pkg::t_func  i_func,
    output logic            o_in_ready,
    output trq_pkg::t_cmd   o_cmd,
    input  trq_pkg::t_sts   i_sts
);
    import trq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_func == FUNC_APPEND) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    if (i_sts.found) begin
                        o_cmd.shift_start = 1'b1;
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.step       = 1'b1;
                o_cmd.shift_mode = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shift only after a search that picked a slot
    a_shift_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> i_sts.found)
        else $error("shift walk without a chosen slot");

    // Appends never walk the list
    a_scan_not_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !i_sts.is_append)
        else $error("search walk started for an append");

    // A result is loaded only into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result loaded over a pending word");

endmodule

`default_nettype wire

@@ sv/trq_datapath.sv @@
// ============================================================================
// trq_datapath: slot memory, walker and result register of the queue
// Slots sit in a one-read, one-write memory. A walker reads one slot a
// cycle, first to search, then to move later slots down over the removed one.
// ============================================================================
`default_nettype none

module trq_datapath #(
    parameter int LIST_DEPTH = trq_pkg::LIST_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  trq_pkg::t_cmd                  i_cmd,
    output trq_pkg::t_sts                  o_sts,
    input  wire [trq_pkg::FUNC_W-1:0]      i_func,
    input  wire [trq_pkg::ID_W-1:0]        i_task_id,
    input  wire [trq_pkg::PRIO_W-1:0]      i_task_priority,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [trq_pkg::STATUS_W-1:0]   o_status,
    output logic [trq_pkg::ID_W-1:0]       o_removed_id,
    output logic [trq_pkg::PRIO_W-1:0]     o_removed_priority
);
    import trq_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int DW = ID_W + PRIO_W;

    // Slot memory: task id in the upper byte, priority in the lower
    logic [DW-1:0] mem [LIST_DEPTH];

    logic [CW-1:0]     r_count;
    t_func             r_func;
    logic [ID_W-1:0]   r_key_id;
    logic [PRIO_W-1:0] r_key_pr;
    logic [CW-1:0]     r_ptr;
    logic              r_pend;
    logic [AW-1:0]     r_pend_pos;
    logic [DW-1:0]     r_rdata;
    logic              r_found;
    logic [AW-1:0]     r_best_pos;
    logic [ID_W-1:0]   r_best_id;
    logic [PRIO_W-1:0] r_best_pr;
    logic              r_out_valid;
    t_status           r_status;
    logic [ID_W-1:0]   r_rid;
    logic [PRIO_W-1:0] r_rpr;

    logic              full;
    logic              issue;
    logic              eval;
    logic              hit;
    logic [ID_W-1:0]   rd_id;
    logic [PRIO_W-1:0] rd_pr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DW-1:0]     wr_data;

    assign full  = (r_count == CW'(LIST_DEPTH));
    assign issue = i_cmd.step && !i_cmd.shift_start && (r_ptr < r_count);
    assign eval  = i_cmd.step && !i_cmd.shift_start && !i_cmd.shift_mode && r_pend;
    assign rd_id = r_rdata[DW-1:PRIO_W];
    assign rd_pr = r_rdata[PRIO_W-1:0];

    // Pick a slot: first for head, first matching id, first greatest priority above zero
    always_comb begin
        case (r_func)
            FUNC_HEAD:  hit = !r_found;
            FUNC_NAMED: hit = !r_found && (rd_id == r_key_id);
            FUNC_PRIO:  hit = (rd_pr > r_best_pr);
            default:    hit = 1'b0;
        endcase
    end

    // Write port: append at the tail, or move a slot down one place
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = {r_key_id, r_key_pr};
        if (i_cmd.finish && (r_func == FUNC_APPEND) && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.step && i_cmd.shift_mode && r_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_pos - AW'(1);
            wr_data = r_rdata;
        end
    end

    // Slot memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rdata <= mem[r_ptr[AW-1:0]];
        end
    end

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= t_func'(i_func);
            r_key_id <= i_task_id;
            r_key_pr <= i_task_priority;
        end
    end

    // Walker and search result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.shift_start) begin
            r_ptr  <= CW'(r_best_pos) + CW'(1);
            r_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_pend <= issue;
            if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (eval && hit) begin
                r_found <= 1'b1;
            end
        end
    end

    // Search payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_pos <= r_ptr[AW-1:0];
        end
        if (i_cmd.capture) begin
            r_best_pr <= '0;
        end else if (eval && hit) begin
            r_best_pos <= r_pend_pos;
            r_best_id  <= rd_id;
            r_best_pr  <= rd_pr;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            if (r_func == FUNC_APPEND) begin
                if (!full) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (r_found) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_func == FUNC_APPEND) begin
                r_status <= full ? STATUS_FULL : STATUS_DONE;
                r_rid    <= '0;
                r_rpr    <= '0;
            end else if (r_found) begin
                r_status <= STATUS_DONE;
                r_rid    <= r_best_id;
                r_rpr    <= r_best_pr;
            end else begin
                r_status <= STATUS_NONE;
                r_rid    <= '0;
                r_rpr    <= '0;
            end
        end
    end

    assign o_sts.is_append = (r_func == FUNC_APPEND);
    assign o_sts.walk_done = (r_ptr == r_count) && !r_pend;
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_id       = r_rid;
    assign o_removed_priority = r_rpr;

    // Count stays within the list
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    // Count moves only when a result is loaded
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_count))
        else $error("entry count changed outside finish");

    // Walker reads only held slots
    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (CW'(r_pend_pos) < r_count))
        else $error("walker read beyond the held slots");

endmodule

`default_nettype wire
